/* rtl/cosine_top_k_search_defines.svh */
// Assertion macros for the cosine top-k search block
`ifndef COSINE_TOP_K_SEARCH_DEFINES_SVH
`define COSINE_TOP_K_SEARCH_DEFINES_SVH

// same-cycle implication, reset masked
`define CTS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cts_pkg.sv */
// Shared types and constants for the cosine top-k search block
package cts_pkg;
    localparam int VALUE_BITS = 16;
    localparam int DOT_W      = 42;
    localparam int NRG_W      = 41;
    localparam int PROD_W     = 82;
    localparam int SRCH_W     = 113;
    localparam int LEN_W      = 11;
    localparam int KC_W       = 5;
    localparam int IDX_W      = 20;
    localparam int TOP_K      = 16;
    localparam int SLOT_W     = 4;
    localparam int MAX_DIM    = 1024;
    localparam int MUL_STEPS  = 41;
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = 2;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    localparam logic REG_VLEN = 1'b0;
    localparam logic REG_KEPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SRCH,
        ST_INS,
        ST_EMIT
    } t_state;

    // one closed database vector
    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [NRG_W-1:0]        nq;
        logic [NRG_W-1:0]        nd;
        logic [IDX_W-1:0]        idx;
        logic                    last;
    } t_vec;

    typedef struct packed {
        logic                empty;
        logic                full;
        logic [FPTR_W:0]     count;
    } t_fifo_stat;
endpackage

/* rtl/cts_front.sv */
// Front end: accumulates dot product and norms, closes vectors
module cts_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [15:0]            i_q,
    input  logic signed [15:0]            i_d,
    input  logic                          i_last,
    input  logic [cts_pkg::LEN_W-1:0]     i_len,
    input  logic                          i_full,
    output logic                          o_push,
    output cts_pkg::t_vec                 o_vec
);
    import cts_pkg::*;

    logic signed [DOT_W-1:0] r_dot, n_dot;
    logic [NRG_W-1:0]        r_nq, n_nq, r_nd, n_nd;
    logic [LEN_W-1:0]        r_elem;
    logic [IDX_W-1:0]        r_vcnt;
    logic signed [31:0]      w_qd, w_qq, w_dd;
    logic                    w_acc, w_close;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;
    assign w_qd    = i_q * i_d;
    assign w_qq    = i_q * i_q;
    assign w_dd    = i_d * i_d;
    assign n_dot   = r_dot + DOT_W'(w_qd);
    assign n_nq    = r_nq + NRG_W'($unsigned(w_qq));
    assign n_nd    = r_nd + NRG_W'($unsigned(w_dd));
    assign w_close = i_last || (({1'b0, r_elem} + 12'd1) >= {1'b0, i_len});

    assign o_push   = w_acc && w_close;
    assign o_vec.dot  = n_dot;
    assign o_vec.nq   = n_nq;
    assign o_vec.nd   = n_nd;
    assign o_vec.idx  = r_vcnt;
    assign o_vec.last = i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot  <= '0;
            r_nq   <= '0;
            r_nd   <= '0;
            r_elem <= '0;
            r_vcnt <= '0;
        end else if (w_acc) begin
            if (w_close) begin
                r_dot  <= '0;
                r_nq   <= '0;
                r_nd   <= '0;
                r_elem <= '0;
                if (i_last) begin
                    r_vcnt <= '0;
                end else if (r_vcnt != IDX_MAX) begin
                    r_vcnt <= r_vcnt + 1'b1;
                end
            end else begin
                r_dot  <= n_dot;
                r_nq   <= n_nq;
                r_nd   <= n_nd;
                r_elem <= r_elem + 1'b1;
            end
        end
    end
endmodule

/* rtl/cts_fifo.sv */
// Short queue of closed vectors between front and back
module cts_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cts_pkg::t_vec        i_vec,
    input  logic                 i_pop,
    output cts_pkg::t_vec        o_vec,
    output cts_pkg::t_fifo_stat  o_stat
);
    import cts_pkg::*;

    t_vec               r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0]  r_wp, r_rp;
    logic [FPTR_W:0]    r_cnt;

    assign o_vec        = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (FPTR_W+1)'(FIFO_DEPTH));
    assign o_stat.count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FPTR_W+1)'(i_push) - (FPTR_W+1)'(i_pop);
        end
    end
endmodule

/* rtl/cts_back.sv */
// Back end: scores a vector, keeps the sorted list, reports it
module cts_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_avail,
    input  cts_pkg::t_vec              i_vec,
    output logic                       o_pop,
    input  logic [cts_pkg::KC_W-1:0]   i_kept,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [cts_pkg::IDX_W-1:0]  o_index,
    output logic signed [15:0]         o_score,
    output logic                       o_entry_valid,
    output logic                       o_last
);
    import cts_pkg::*;

    t_state r_state, n_state;

    logic                    r_neg, r_zero, r_last;
    logic [IDX_W-1:0]        r_idx;
    logic [NRG_W-1:0]        r_mq, r_md;
    logic [PROD_W-1:0]       r_ap, r_ad, r_p, r_dd;
    logic [PROD_W-1:0]       w_p_nxt, w_d_nxt;
    logic [5:0]              r_cnt;
    logic [SRCH_W-1:0]       r_a, r_bsh, r_psh, r_t, w_cand;
    logic [15:0]             r_s, r_mask;
    logic signed [DOT_W-1:0] w_mag_s;
    logic signed [15:0]      w_score;
    logic                    w_take, w_load, w_last_slot;
    logic [SLOT_W-1:0]       r_slot;

    logic signed [15:0]      r_bs [TOP_K];
    logic [IDX_W-1:0]        r_bi [TOP_K];
    logic [TOP_K-1:0]        r_bv, w_ge;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_avail) n_state = ST_MUL;
            ST_MUL:  if (r_cnt == '0) n_state = ST_SRCH;
            ST_SRCH: if (r_mask[0]) n_state = ST_INS;
            ST_INS:  n_state = r_last ? ST_EMIT : ST_IDLE;
            ST_EMIT: if (w_load && w_last_slot) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        case (r_state)
            ST_IDLE: o_pop  = i_avail;
            ST_EMIT: w_load = !o_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    assign w_mag_s  = i_vec.dot[DOT_W-1] ? -i_vec.dot : i_vec.dot;
    assign w_p_nxt  = r_mq[0] ? r_p + r_ap : r_p;
    assign w_d_nxt  = r_md[0] ? r_dd + r_ad : r_dd;
    assign w_cand   = r_a + r_bsh + r_psh;
    assign w_take   = (w_cand <= r_t);

    always_comb begin
        if (r_zero)     w_score = '0;
        else if (r_neg) w_score = 16'(-{1'b0, r_s});
        else if (r_s[15]) w_score = 16'sh7FFF;
        else            w_score = r_s;
    end

    // slot i holds a score that stays ahead of the new one
    always_comb begin
        for (int i = 0; i < TOP_K; i++) begin
            w_ge[i] = r_bv[i] && (r_bs[i] >= w_score);
        end
    end

    // multiply and root search datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_neg  <= i_vec.dot[DOT_W-1];
                r_zero <= (i_vec.nq == '0) || (i_vec.nd == '0);
                r_last <= i_vec.last;
                r_idx  <= i_vec.idx;
                r_mq   <= i_vec.nq;
                r_ap   <= PROD_W'(i_vec.nd);
                r_md   <= w_mag_s[NRG_W-1:0];
                r_ad   <= PROD_W'(w_mag_s[NRG_W-1:0]);
                r_p    <= '0;
                r_dd   <= '0;
                r_cnt  <= 6'(MUL_STEPS - 1);
            end
            ST_MUL: begin
                r_p   <= w_p_nxt;
                r_dd  <= w_d_nxt;
                r_mq  <= r_mq >> 1;
                r_md  <= r_md >> 1;
                r_ap  <= r_ap << 1;
                r_ad  <= r_ad << 1;
                r_cnt <= r_cnt - 1'b1;
                r_psh <= SRCH_W'(w_p_nxt) << 30;
                r_t   <= SRCH_W'(w_d_nxt) << 30;
                r_a   <= '0;
                r_bsh <= '0;
                r_s   <= '0;
                r_mask <= 16'h8000;
            end
            ST_SRCH: begin
                if (w_take) begin
                    r_a   <= w_cand;
                    r_bsh <= (r_bsh >> 1) + r_psh;
                    r_s   <= r_s | r_mask;
                end else begin
                    r_bsh <= r_bsh >> 1;
                end
                r_psh  <= r_psh >> 2;
                r_mask <= r_mask >> 1;
            end
            default: ;
        endcase
    end

    // sorted list payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_INS) begin
            for (int i = 0; i < TOP_K; i++) begin
                if (!w_ge[i]) begin
                    if (i == 0 || w_ge[(i == 0) ? 0 : i-1]) begin
                        r_bs[i] <= w_score;
                        r_bi[i] <= r_idx;
                    end else begin
                        r_bs[i] <= r_bs[(i == 0) ? 0 : i-1];
                        r_bi[i] <= r_bi[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end
    end

    assign w_last_slot = ({1'b0, r_slot} == (i_kept - 5'd1));

    // valid bits, emit counter, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv    <= '0;
            r_slot  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (r_state == ST_INS) begin
                for (int i = 0; i < TOP_K; i++) begin
                    if (!w_ge[i]) begin
                        if (i == 0 || w_ge[(i == 0) ? 0 : i-1]) r_bv[i] <= 1'b1;
                        else r_bv[i] <= r_bv[(i == 0) ? 0 : i-1];
                    end
                end
            end
            if (w_load) begin
                o_valid <= 1'b1;
                if (w_last_slot) begin
                    r_bv   <= '0;
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_entry_valid <= r_bv[r_slot];
            o_index       <= r_bv[r_slot] ? r_bi[r_slot] : '0;
            o_score       <= r_bv[r_slot] ? r_bs[r_slot] : '0;
            o_last        <= w_last_slot;
        end
    end
endmodule

/* rtl/cosine_top_k_search.sv */
// Top level: brute-force top-k cosine similarity search
// Input side takes one element pair per cycle while the vector queue has room.
// Each closed vector passes through the scorer in turn: a load, the shift-add
// multiplier (both norm and dot products), 16 root-search steps, an insert.
// On a batch's last element, kept_count entries follow, one per cycle unless stalled.
// Synchronous active-low reset clears sums, counters, the list and the queue.
module cosine_top_k_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis tdata: query_value[15:0], database_value[31:16]
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    // m_axis tdata: entry_index[19:0], entry_score[35:20], zero pad [39:36]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,
    // m_axis tuser: entry_valid
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cts_pkg::*;
    `include "cosine_top_k_search_defines.svh"

    logic [LEN_W-1:0]   r_vlen, w_len;
    logic [KC_W-1:0]    r_kept, w_kept;
    logic               w_push, w_pop;
    t_vec               w_in_vec, w_out_vec;
    t_fifo_stat         w_stat;
    logic [IDX_W-1:0]   w_index;
    logic signed [15:0] w_score;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= 11'd128;
            r_kept <= 5'd8;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_VLEN: r_vlen <= pwdata[LEN_W-1:0];
                REG_KEPT: r_kept <= pwdata[KC_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_VLEN: prdata = 32'(r_vlen);
            REG_KEPT: prdata = 32'(r_kept);
            default:  prdata = '0;
        endcase
    end

    // out-of-range settings clamp to the legal range
    assign w_len  = (r_vlen == '0) ? 11'd1 :
                    (r_vlen > LEN_W'(MAX_DIM)) ? LEN_W'(MAX_DIM) : r_vlen;
    assign w_kept = (r_kept == '0) ? 5'd1 :
                    (r_kept > KC_W'(TOP_K)) ? KC_W'(TOP_K) : r_kept;

    cts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_q     (i_s_axis_tdata[15:0]),
        .i_d     (i_s_axis_tdata[31:16]),
        .i_last  (i_s_axis_tlast),
        .i_len   (w_len),
        .i_full  (w_stat.full),
        .o_push  (w_push),
        .o_vec   (w_in_vec)
    );

    cts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_vec   (w_in_vec),
        .i_pop   (w_pop),
        .o_vec   (w_out_vec),
        .o_stat  (w_stat)
    );

    cts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (!w_stat.empty),
        .i_vec         (w_out_vec),
        .o_pop         (w_pop),
        .i_kept        (w_kept),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_index       (w_index),
        .o_score       (w_score),
        .o_entry_valid (o_m_axis_tuser),
        .o_last        (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0, w_score, w_index};

    // queue never pops empty nor overfills
    `CTS_ASSERT_IMPL(a_no_pop_empty, w_pop, !w_stat.empty, "pop from empty vector queue")
    `CTS_ASSERT_IMPL(a_cnt_bound, 1'b1, w_stat.count <= (FPTR_W+1)'(FIFO_DEPTH),
                     "vector queue count overflow")
    // empty slots carry zero payload
    `CTS_ASSERT_IMPL(a_empty_zero, o_m_axis_tvalid && !o_m_axis_tuser,
                     o_m_axis_tdata == '0, "empty slot with nonzero payload")
    // a full queue pushes nothing further
    `CTS_ASSERT_NEXT(a_full_hold, w_stat.full && !w_pop, !w_push || w_stat.full,
                     "push into full vector queue")
endmodule
